FILE: hw/rtl/acf_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the 3-bit adpcm codec
package acf_pkg;

    localparam int unsigned MaxIndex = 88;

    // operation codes, equal to the input mode codes
    typedef enum logic [1:0] {
        OP_ENC  = 2'd0,
        OP_DEC  = 2'd1,
        OP_LOAD = 2'd2,
        OP_HDR  = 2'd3
    } t_op;

    // result kinds
    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_HEADER = 2'd2
    } t_kind;

    // one queued operation
    typedef struct packed {
        t_op                op;
        logic signed [15:0] value;   // sample to encode or start predictor
        logic [6:0]         index;   // saturated start index
        logic               eof;
        logic [8:0]         codes;   // unpacked codes, first one on top
        logic               three;   // third code present
    } t_entry;

endpackage

FILE: hw/rtl/acf_front.sv
`timescale 1ns / 1ps
// front end: classifies input words and unpacks code bytes into queue entries
module acf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_mode,
    input  logic signed [15:0]  i_sample,
    input  logic [7:0]          i_packed_byte,
    input  logic signed [15:0]  i_start_predictor,
    input  logic [6:0]          i_start_index,
    input  logic                i_end_of_frame,
    output acf_pkg::t_entry     o_entry
);

    logic [1:0] r_ub;
    logic [1:0] r_ucnt;
    logic [1:0] n_ub;
    logic [1:0] n_ucnt;
    logic [9:0] w_bits;
    logic [9:0] w_aligned;
    acf_pkg::t_op w_op;

    assign w_op      = acf_pkg::t_op'(i_mode);
    assign w_bits    = {r_ub, i_packed_byte};
    // put the oldest leftover bit at the top of the window
    assign w_aligned = 10'(w_bits << (2'd2 - r_ucnt));

    always_comb begin
        o_entry.op    = w_op;
        o_entry.value = (w_op == acf_pkg::OP_LOAD) ? i_start_predictor : i_sample;
        o_entry.index = (i_start_index > 7'(acf_pkg::MaxIndex)) ?
                        7'(acf_pkg::MaxIndex) : i_start_index;
        o_entry.eof   = i_end_of_frame;
        o_entry.codes = {w_aligned[9:7], w_aligned[6:4], w_aligned[3:1]};
        o_entry.three = (r_ucnt != 2'd0);

        n_ub   = r_ub;
        n_ucnt = r_ucnt;
        if (w_op == acf_pkg::OP_DEC) begin
            case (r_ucnt)
                2'd1: begin
                    n_ub   = 2'd0;
                    n_ucnt = 2'd0;
                end
                2'd2: begin
                    n_ub   = {1'b0, i_packed_byte[0]};
                    n_ucnt = 2'd1;
                end
                default: begin
                    n_ub   = i_packed_byte[1:0];
                    n_ucnt = 2'd2;
                end
            endcase
        end else if (w_op == acf_pkg::OP_LOAD) begin
            n_ub   = 2'd0;
            n_ucnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ub   <= 2'd0;
            r_ucnt <= 2'd0;
        end else if (i_accept) begin
            r_ub   <= n_ub;
            r_ucnt <= n_ucnt;
        end
    end

endmodule

FILE: hw/rtl/acf_queue.sv
`timescale 1ns / 1ps
// two-entry queue between front end and back end
module acf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  acf_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output acf_pkg::t_entry o_entry
);

    acf_pkg::t_entry r_mem [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

FILE: hw/rtl/acf_back.sv
`timescale 1ns / 1ps
// back end: encoder and decoder predictors, bit packer and output register
module acf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_op_valid,
    input  acf_pkg::t_entry     i_op,
    output logic                o_pop,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_out_byte,
    output logic signed [15:0]  o_out_sample,
    output logic [6:0]          o_out_index,
    output logic                o_last
);

    localparam logic [14:0] StepTable [0:88] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
        15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
        15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
        15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
        15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
        15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
        15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
        15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
        15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
        15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
        15'd27086, 15'd29794, 15'd32767
    };

    function automatic logic [14:0] step_size(input logic [6:0] idx);
        if (idx > 7'(acf_pkg::MaxIndex)) begin
            return StepTable[acf_pkg::MaxIndex];
        end
        return StepTable[idx];
    endfunction

    function automatic logic [6:0] next_index(input logic [6:0] idx, input logic [1:0] mag);
        logic [6:0] sum;
        sum = idx + ((mag == 2'd3) ? 7'd8 : 7'd4);
        if (mag[1] == 1'b0) begin
            return (idx == 7'd0) ? 7'd0 : idx - 7'd1;
        end
        return (sum > 7'(acf_pkg::MaxIndex)) ? 7'(acf_pkg::MaxIndex) : sum;
    endfunction

    // predictor update with 16-bit saturation
    function automatic logic signed [15:0] predict(input logic signed [15:0] pred,
                                                   input logic [14:0] step,
                                                   input logic [2:0] code);
        logic [16:0]        vp;
        logic signed [17:0] pe;
        logic signed [17:0] ve;
        logic signed [17:0] sum;
        vp  = {4'd0, step[14:2]} + (code[1] ? {2'd0, step} : 17'd0)
            + (code[0] ? {3'd0, step[14:1]} : 17'd0);
        pe  = {{2{pred[15]}}, pred};
        ve  = {1'b0, vp};
        sum = code[2] ? pe - ve : pe + ve;
        if (sum > 18'sd32767) begin
            return 16'sh7fff;
        end
        if (sum < -18'sd32768) begin
            return 16'sh8000;
        end
        return sum[15:0];
    endfunction

    logic signed [15:0] r_enc_pred;
    logic [6:0]         r_enc_idx;
    logic [7:0]         r_pack_buf;
    logic [2:0]         r_pack_cnt;
    logic signed [15:0] r_dec_pred;
    logic [6:0]         r_dec_idx;
    logic [1:0]         r_sub;

    logic signed [15:0] n_enc_pred;
    logic [6:0]         n_enc_idx;
    logic [7:0]         n_pack_buf;
    logic [2:0]         n_pack_cnt;
    logic signed [15:0] n_dec_pred;
    logic [6:0]         n_dec_idx;
    logic [1:0]         n_sub;

    logic               r_o_valid;
    logic [1:0]         r_kind;
    logic [7:0]         r_byte;
    logic signed [15:0] r_sample;
    logic [6:0]         r_index;
    logic               r_last;

    logic               w_free;
    logic               w_go;
    logic               w_emit;
    acf_pkg::t_kind     w_kind;
    logic [7:0]         w_byte;
    logic signed [15:0] w_sample;
    logic [6:0]         w_index;
    logic               w_last;

    // encoder datapath
    logic [14:0]        w_step_e;
    logic signed [16:0] w_diff;
    logic [16:0]        w_absd;
    logic [16:0]        w_rem;
    logic [2:0]         w_code_e;
    logic [10:0]        w_window;
    logic               w_full;
    logic [7:0]         w_buf_after;
    logic [2:0]         w_cnt_after;

    // decoder datapath
    logic [2:0]         w_code_d;
    logic               w_dec_end;

    assign w_free = !r_o_valid || !i_stall;
    assign w_go   = i_op_valid && w_free;

    always_comb begin
        w_step_e    = step_size(r_enc_idx);
        w_diff      = {i_op.value[15], i_op.value} - {r_enc_pred[15], r_enc_pred};
        w_absd      = w_diff[16] ? 17'(-w_diff) : 17'(w_diff);
        w_code_e[2] = w_diff[16];
        w_code_e[1] = (w_absd >= {2'd0, w_step_e});
        w_rem       = w_code_e[1] ? w_absd - {2'd0, w_step_e} : w_absd;
        w_code_e[0] = (w_rem >= {3'd0, w_step_e[14:1]});
        // code lands right under the bits already in the buffer
        w_window    = {r_pack_buf, 3'd0} | 11'({8'd0, w_code_e} << (4'd8 - {1'b0, r_pack_cnt}));
        w_full      = (r_pack_cnt >= 3'd5);
        w_buf_after = w_full ? {w_window[2:0], 5'd0} : w_window[10:3];
        w_cnt_after = w_full ? r_pack_cnt - 3'd5 : r_pack_cnt + 3'd3;

        case (r_sub)
            2'd0:    w_code_d = i_op.codes[8:6];
            2'd1:    w_code_d = i_op.codes[5:3];
            default: w_code_d = i_op.codes[2:0];
        endcase
        w_dec_end = (r_sub == 2'd2) || (!i_op.three && r_sub == 2'd1);
    end

    always_comb begin
        n_enc_pred = r_enc_pred;
        n_enc_idx  = r_enc_idx;
        n_pack_buf = r_pack_buf;
        n_pack_cnt = r_pack_cnt;
        n_dec_pred = r_dec_pred;
        n_dec_idx  = r_dec_idx;
        n_sub      = r_sub;
        o_pop      = 1'b0;
        w_emit     = 1'b0;
        w_kind     = acf_pkg::KIND_BYTE;
        w_byte     = 8'd0;
        w_sample   = 16'sd0;
        w_index    = 7'd0;
        w_last     = 1'b0;

        if (w_go) begin
            unique case (i_op.op)
                acf_pkg::OP_ENC: begin
                    if (r_sub == 2'd0) begin
                        n_enc_pred = predict(r_enc_pred, w_step_e, w_code_e);
                        n_enc_idx  = next_index(r_enc_idx, w_code_e[1:0]);
                        n_pack_buf = w_buf_after;
                        n_pack_cnt = w_cnt_after;
                        o_pop      = 1'b1;
                        if (w_full) begin
                            w_emit = 1'b1;
                            w_byte = w_window[10:3];
                            w_last = 1'b1;
                        end
                        if (i_op.eof) begin
                            n_pack_buf = 8'd0;
                            n_pack_cnt = 3'd0;
                            if (w_cnt_after != 3'd0) begin
                                if (w_full) begin
                                    // flush byte goes out from the held buffer in the r_sub == 1 step
                                    n_pack_buf = w_buf_after;
                                    n_pack_cnt = w_cnt_after;
                                    w_last     = 1'b0;
                                    o_pop      = 1'b0;
                                    n_sub      = 2'd1;
                                end else begin
                                    w_emit = 1'b1;
                                    w_byte = w_buf_after;
                                    w_last = 1'b1;
                                end
                            end
                        end
                    end else begin
                        w_emit     = 1'b1;
                        w_byte     = r_pack_buf;
                        w_last     = 1'b1;
                        n_pack_buf = 8'd0;
                        n_pack_cnt = 3'd0;
                        n_sub      = 2'd0;
                        o_pop      = 1'b1;
                    end
                end
                acf_pkg::OP_DEC: begin
                    n_dec_pred = predict(r_dec_pred, step_size(r_dec_idx), w_code_d);
                    n_dec_idx  = next_index(r_dec_idx, w_code_d[1:0]);
                    w_emit     = 1'b1;
                    w_kind     = acf_pkg::KIND_SAMPLE;
                    w_sample   = n_dec_pred;
                    w_last     = w_dec_end;
                    if (w_dec_end) begin
                        n_sub = 2'd0;
                        o_pop = 1'b1;
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
                acf_pkg::OP_LOAD: begin
                    n_dec_pred = i_op.value;
                    n_dec_idx  = i_op.index;
                    o_pop      = 1'b1;
                end
                acf_pkg::OP_HDR: begin
                    n_pack_buf = 8'd0;
                    n_pack_cnt = 3'd0;
                    w_emit     = 1'b1;
                    w_kind     = acf_pkg::KIND_HEADER;
                    w_sample   = r_enc_pred;
                    w_index    = r_enc_idx;
                    w_last     = 1'b1;
                    o_pop      = 1'b1;
                end
                default: begin
                    o_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc_pred <= 16'sd0;
            r_enc_idx  <= 7'd0;
            r_pack_buf <= 8'd0;
            r_pack_cnt <= 3'd0;
            r_dec_pred <= 16'sd0;
            r_dec_idx  <= 7'd0;
            r_sub      <= 2'd0;
            r_o_valid  <= 1'b0;
        end else begin
            r_enc_pred <= n_enc_pred;
            r_enc_idx  <= n_enc_idx;
            r_pack_buf <= n_pack_buf;
            r_pack_cnt <= n_pack_cnt;
            r_dec_pred <= n_dec_pred;
            r_dec_idx  <= n_dec_idx;
            r_sub      <= n_sub;
            if (w_free) begin
                r_o_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free && w_emit) begin
            r_kind   <= w_kind;
            r_byte   <= w_byte;
            r_sample <= w_sample;
            r_index  <= w_index;
            r_last   <= w_last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_kind       = r_kind;
    assign o_out_byte   = r_byte;
    assign o_out_sample = r_sample;
    assign o_out_index  = r_index;
    assign o_last       = r_last;

    a_enc_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_enc_idx <= 7'(acf_pkg::MaxIndex))
        else $error("encoder step index out of range");

    a_dec_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dec_idx <= 7'(acf_pkg::MaxIndex))
        else $error("decoder step index out of range");

    a_sub_has_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub != 2'd0) |-> i_op_valid)
        else $error("operation in progress but queue is empty");

    a_enc_one_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub != 2'd0 && i_op.op == acf_pkg::OP_ENC) |-> (r_sub == 2'd1))
        else $error("encode step counter past flush");

endmodule

FILE: hw/rtl/adpcm_3bit_codec_top.sv
`timescale 1ns / 1ps
// top level of the 3-bit adpcm codec
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------------
//  input   | i_valid / o_stall  | i_mode i_sample i_packed_byte i_start_predictor
//          |                    | i_start_index i_end_of_frame
//  output  | o_valid / i_stall  | o_kind o_out_byte o_out_sample o_out_index o_last
//
// a word enters the two-entry queue in the cycle it is accepted; the back end
// works while the output register is free: an encoded sample gives a byte when
// the packer fills, then at end of frame a flush byte of leftover codes; a packed
// byte gives two or three samples, a header word one header, a load word no result
// o_stall rises only while the queue is full; the output register frees when taken
// synchronous active-low reset clears all predictor, index and packer state
module adpcm_3bit_codec_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_mode,
    input  logic signed [15:0]  i_sample,
    input  logic [7:0]          i_packed_byte,
    input  logic signed [15:0]  i_start_predictor,
    input  logic [6:0]          i_start_index,
    input  logic                i_end_of_frame,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_out_byte,
    output logic signed [15:0]  o_out_sample,
    output logic [6:0]          o_out_index,
    output logic                o_last
);

    acf_pkg::t_entry w_new;
    acf_pkg::t_entry w_head;
    logic            w_full;
    logic            w_accept;
    logic            w_head_valid;
    logic            w_pop;

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    acf_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (w_accept),
        .i_mode            (i_mode),
        .i_sample          (i_sample),
        .i_packed_byte     (i_packed_byte),
        .i_start_predictor (i_start_predictor),
        .i_start_index     (i_start_index),
        .i_end_of_frame    (i_end_of_frame),
        .o_entry           (w_new)
    );

    acf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_entry (w_new),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_entry (w_head)
    );

    acf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_valid   (w_head_valid),
        .i_op         (w_head),
        .o_pop        (w_pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_out_sample (o_out_sample),
        .o_out_index  (o_out_index),
        .o_last       (o_last)
    );

endmodule
